// ----- hw/rtl/ydqe_pkg.sv -----
// Package for the YAML double-quoted scalar escaper.
// Holds the item structs, the escape kind codes, character constants and the hex digit function.
// Has no dependencies.
package ydqe_pkg;

	// One decoded character as it enters the block.
	typedef struct packed {
		logic [20:0] char_code;
		logic        valid_req;
		logic [2:0]  byte_count;
		logic [7:0]  raw_byte0;
		logic [7:0]  raw_byte1;
		logic [7:0]  raw_byte2;
		logic [7:0]  raw_byte3;
	} req_item_t;

	// One byte of escaped text as it leaves the block.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} rsp_item_t;

	// How a character is rendered.
	typedef enum logic [2:0] {
		KIND_ESC2,  // backslash and one character
		KIND_PASS,  // original UTF-8 bytes
		KIND_HEX2,  // \xNN
		KIND_HEX4,  // \uNNNN
		KIND_HEX8   // \UNNNNNNNN
	} kind_t;

	localparam int unsigned MaxBytes = 10;
	localparam int unsigned CntW     = 4;

	localparam logic [7:0] ChBackslash = 8'h5C;
	localparam logic [7:0] ChQuote     = 8'h22;
	localparam logic [7:0] ChLowerN    = 8'h6E;
	localparam logic [7:0] ChLowerT    = 8'h74;
	localparam logic [7:0] ChLowerR    = 8'h72;
	localparam logic [7:0] ChLowerX    = 8'h78;
	localparam logic [7:0] ChLowerU    = 8'h75;
	localparam logic [7:0] ChUpperU    = 8'h55;

	localparam logic [20:0] CpMax      = 21'h10FFFF;
	localparam logic [20:0] CpTab      = 21'h000009;
	localparam logic [20:0] CpLf       = 21'h00000A;
	localparam logic [20:0] CpCr       = 21'h00000D;
	localparam logic [20:0] CpQuote    = 21'h000022;
	localparam logic [20:0] CpBackslash = 21'h00005C;
	localparam logic [20:0] CpNel      = 21'h000085;
	localparam logic [20:0] CpLsep     = 21'h002028;
	localparam logic [20:0] CpPsep     = 21'h002029;

	// Uppercase hex digit for one nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] wide;
		wide = {4'b0000, nib};
		if (nib < 4'd10) begin
			return 8'h30 + wide;
		end else begin
			return 8'h37 + wide;
		end
	endfunction

endpackage

// ----- hw/rtl/yaml_double_quote_escaper_unit.sv -----
// Top level of the YAML double-quoted scalar escaper.
// Three pipeline stages (capture, classify, expand) feed a byte serializer.
// Depends on ydqe_pkg.
//
// Path: an accepted item passes stages 1, 2 and 3, then the serializer drives rsp.
// Throughput: the serializer sends one byte per cycle unless rsp_stall is high; the
//   stages ahead take an item every cycle unless stalled; escaped text is 1 to 10 bytes.
// Reset: arst_n clears all valid bits and the byte index; payload registers are not reset.
module yaml_double_quote_escaper_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  ydqe_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output ydqe_pkg::rsp_item_t rsp
);
	import ydqe_pkg::*;

	// Stage 1: the accepted item, registered as it came in.
	logic      valid_s1;
	req_item_t item_s1;

	// Stage 2: the rendering decision for the character.
	logic       valid_s2;
	kind_t      kind_s2;
	logic [20:0] val_s2;
	logic [7:0] esc_s2;
	logic [2:0] cnt_s2;
	logic [3:0][7:0] raw_s2;

	// Stage 3: the escaped text laid out byte by byte.
	logic                       valid_s3;
	logic [MaxBytes-1:0][7:0]   buf_s3;
	logic [CntW-1:0]            cnt_s3;

	// Serializer: holds one item's text and walks through it.
	logic                       ser_valid_q;
	logic [MaxBytes-1:0][7:0]   ser_buf_q;
	logic [CntW-1:0]            ser_cnt_q;
	logic [CntW-1:0]            ser_idx_q;

	logic ser_last;
	logic ser_load, s3_load, s2_load, s1_load;

	// Each stage moves when it is empty or its contents move on. The serializer frees
	// itself when its final byte is taken.
	assign ser_last = (ser_idx_q == ser_cnt_q - 1'b1);
	assign ser_load = !ser_valid_q || (!rsp_stall && ser_last);
	assign s3_load  = !valid_s3 || ser_load;
	assign s2_load  = !valid_s2 || s3_load;
	assign s1_load  = !valid_s1 || s2_load;
	assign req_stall = !s1_load;

	assign rsp_valid      = ser_valid_q;
	assign rsp.out_byte   = ser_buf_q[ser_idx_q];
	assign rsp.last_byte  = ser_last;

	// Classification of the character held in stage 1, in the priority order of the
	// escaping rules: broken sequence first, then the two-character escapes, then the
	// printable non-break characters, then the numeric escapes by size.
	kind_t       kind_d;
	logic [20:0] val_d;
	logic [7:0]  esc_d;
	logic [2:0]  cnt_d;
	logic        printable;
	logic        line_break;
	logic [20:0] cp;

	always_comb begin
		cp = item_s1.char_code;
		printable = (cp == CpTab) || (cp == CpLf) || (cp == CpCr) ||
			(cp >= 21'h20 && cp <= 21'h7E) || (cp == CpNel) ||
			(cp >= 21'hA0 && cp <= 21'hD7FF) ||
			(cp >= 21'hE000 && cp <= 21'hFFFD) ||
			(cp >= 21'h10000 && cp <= CpMax);
		line_break = (cp == CpLf) || (cp == CpCr) || (cp == CpNel) ||
			(cp == CpLsep) || (cp == CpPsep);
		val_d = cp;
		esc_d = ChBackslash;
		// An out-of-range byte count is clamped into 1..4.
		if (item_s1.byte_count == 3'd0) begin
			cnt_d = 3'd1;
		end else if (item_s1.byte_count > 3'd4) begin
			cnt_d = 3'd4;
		end else begin
			cnt_d = item_s1.byte_count;
		end
		if (!item_s1.valid_req) begin
			kind_d = KIND_HEX2;
			val_d  = {13'b0, item_s1.raw_byte0};
		end else if (cp == CpBackslash) begin
			kind_d = KIND_ESC2;
			esc_d  = ChBackslash;
		end else if (cp == CpQuote) begin
			kind_d = KIND_ESC2;
			esc_d  = ChQuote;
		end else if (cp == CpLf) begin
			kind_d = KIND_ESC2;
			esc_d  = ChLowerN;
		end else if (cp == CpTab) begin
			kind_d = KIND_ESC2;
			esc_d  = ChLowerT;
		end else if (cp == CpCr) begin
			kind_d = KIND_ESC2;
			esc_d  = ChLowerR;
		end else if (printable && !line_break) begin
			kind_d = KIND_PASS;
		end else if (cp <= 21'h7F) begin
			kind_d = KIND_HEX2;
		end else if (cp <= 21'hFFFF) begin
			kind_d = KIND_HEX4;
		end else begin
			kind_d = KIND_HEX8;
		end
	end

	// Expansion of the stage 2 decision into the byte buffer and its length.
	logic [MaxBytes-1:0][7:0] buf_d;
	logic [CntW-1:0]          len_d;
	logic [31:0]              v32;

	always_comb begin
		v32   = {11'b0, val_s2};
		buf_d = '0;
		len_d = '0;
		buf_d[0] = ChBackslash;
		case (kind_s2)
			KIND_ESC2: begin
				buf_d[1] = esc_s2;
				len_d    = CntW'(2);
			end
			KIND_PASS: begin
				buf_d[0] = raw_s2[0];
				buf_d[1] = raw_s2[1];
				buf_d[2] = raw_s2[2];
				buf_d[3] = raw_s2[3];
				len_d    = {1'b0, cnt_s2};
			end
			KIND_HEX2: begin
				buf_d[1] = ChLowerX;
				for (int i = 0; i < 2; i++) begin
					buf_d[2+i] = hex_char(v32[(1-i)*4 +: 4]);
				end
				len_d = CntW'(4);
			end
			KIND_HEX4: begin
				buf_d[1] = ChLowerU;
				for (int i = 0; i < 4; i++) begin
					buf_d[2+i] = hex_char(v32[(3-i)*4 +: 4]);
				end
				len_d = CntW'(6);
			end
			KIND_HEX8: begin
				buf_d[1] = ChUpperU;
				for (int i = 0; i < 8; i++) begin
					buf_d[2+i] = hex_char(v32[(7-i)*4 +: 4]);
				end
				len_d = CntW'(10);
			end
			default: begin
				len_d = CntW'(2);
			end
		endcase
	end

	// Valid bits and the byte index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			ser_valid_q <= 1'b0;
			ser_idx_q   <= '0;
		end else begin
			if (s1_load) begin
				valid_s1 <= req_valid;
			end
			if (s2_load) begin
				valid_s2 <= valid_s1;
			end
			if (s3_load) begin
				valid_s3 <= valid_s2;
			end
			if (ser_load) begin
				ser_valid_q <= valid_s3;
				ser_idx_q   <= '0;
			end else if (!rsp_stall) begin
				ser_idx_q <= ser_idx_q + 1'b1;
			end
		end
	end

	// Payload registers follow their valid bits and need no reset.
	always_ff @(posedge clk) begin
		if (s1_load) begin
			item_s1 <= req;
		end
		if (s2_load) begin
			kind_s2 <= kind_d;
			val_s2  <= val_d;
			esc_s2  <= esc_d;
			cnt_s2  <= cnt_d;
			raw_s2  <= {item_s1.raw_byte3, item_s1.raw_byte2,
				item_s1.raw_byte1, item_s1.raw_byte0};
		end
		if (s3_load) begin
			buf_s3 <= buf_d;
			cnt_s3 <= len_d;
		end
		if (ser_load) begin
			ser_buf_q <= buf_s3;
			ser_cnt_q <= cnt_s3;
		end
	end

	// The byte index never runs past the end of the held text.
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ser_valid_q |-> (ser_idx_q < ser_cnt_q))
		else $error("serializer index beyond text length");

	// Every held text is between one and ten bytes long.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		ser_valid_q |-> (ser_cnt_q >= CntW'(1) && ser_cnt_q <= CntW'(MaxBytes)))
		else $error("serializer text length out of range");

	// A stage 1 item that cannot move on is still there in the next cycle.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s2_load) |=> valid_s1)
		else $error("stage 1 item lost while stalled");

endmodule
